[rtl/gpio_expander_port_change_detect_core_defines.svh]
// Assertion macros shared by the checker of the port change detector.
`ifndef GPIO_EXPANDER_PORT_CHANGE_DETECT_CORE_DEFINES_SVH
`define GPIO_EXPANDER_PORT_CHANGE_DETECT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GPEC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define GPEC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

[rtl/gpec_pkg.sv]
// Package of types, codes and constants for the port change detector.
`timescale 1ns / 1ps

package gpec_pkg;

	localparam int PORT_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	// Operation codes.
	localparam logic [2:0] OP_WRITE_PORT = 3'd0;
	localparam logic [2:0] OP_WRITE_PIN  = 3'd1;
	localparam logic [2:0] OP_READ_PIN   = 3'd2;
	localparam logic [2:0] OP_READ_PORT  = 3'd3;
	localparam logic [2:0] OP_RESET_PORT = 3'd4;
	localparam logic [2:0] OP_SCAN       = 3'd5;

	// Result kinds.
	localparam logic [1:0] KIND_SENT  = 2'd0;
	localparam logic [1:0] KIND_PORT  = 2'd1;
	localparam logic [1:0] KIND_PIN   = 2'd2;
	localparam logic [1:0] KIND_EVENT = 2'd3;

	typedef struct packed {
		logic [2:0]  operation;
		logic [15:0] port_value;
		logic [3:0]  pin_index;
		logic        pin_level;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] port_word;
		logic [3:0]  pin_number;
		logic        level_out;
		logic        last;
	} out_item_t;

	// One job handed from the front end to the back end.
	typedef struct packed {
		logic        scan;
		logic [1:0]  kind;
		logic [15:0] word;
		logic [3:0]  pin;
		logic        level;
		logic [15:0] changed;
	} job_t;

endpackage

[rtl/gpec_queue.sv]
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module gpec_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gpec_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            avail,
	output gpec_pkg::job_t  head
);

	localparam int DEPTH = gpec_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	gpec_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign avail   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && avail;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/gpec_front.sv]
// Front end: takes operations, keeps the port latch and mask, queues result jobs.
`timescale 1ns / 1ps

module gpec_front #(
	parameter int PORT_WIDTH = gpec_pkg::PORT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gpec_pkg::in_item_t  in_data,
	input  logic                cfg_valid,
	input  logic [15:0]         cfg_data,
	input  logic                q_full,
	output logic                q_push,
	output gpec_pkg::job_t      q_job
);

	localparam logic [15:0] WMASK = (PORT_WIDTH >= 16) ? 16'hFFFF
		: 16'((32'd1 << PORT_WIDTH) - 32'd1);

	logic [15:0] mask_q;
	logic [15:0] latch_q;
	logic [15:0] latch_d;
	logic        latch_we;
	logic        want_push;
	logic [15:0] val;
	logic [15:0] mask;
	logic [15:0] pin_bit;
	logic [15:0] word;
	logic [15:0] diff;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign val      = in_data.port_value & WMASK;
	assign mask     = mask_q & WMASK;
	assign pin_bit  = (32'(in_data.pin_index) < PORT_WIDTH)
		? ((16'd1 << in_data.pin_index) & WMASK) : 16'd0;
	assign diff     = (latch_q ^ val) & mask;

	always_comb begin
		word      = '0;
		latch_d   = latch_q;
		latch_we  = 1'b0;
		want_push = 1'b0;
		q_job     = '0;
		case (in_data.operation)
			gpec_pkg::OP_WRITE_PORT: begin
				word       = (val | mask) & WMASK;
				latch_d    = word;
				latch_we   = 1'b1;
				want_push  = 1'b1;
				q_job.kind = gpec_pkg::KIND_SENT;
				q_job.word = word;
			end
			gpec_pkg::OP_WRITE_PIN: begin
				if (in_data.pin_level) begin
					word = (latch_q | mask | pin_bit) & WMASK;
				end else begin
					word = ((latch_q & ~pin_bit) | mask) & WMASK;
				end
				latch_d     = word;
				latch_we    = 1'b1;
				want_push   = 1'b1;
				q_job.kind  = gpec_pkg::KIND_SENT;
				q_job.word  = word;
				q_job.pin   = in_data.pin_index;
				q_job.level = |(word & pin_bit);
			end
			gpec_pkg::OP_READ_PIN: begin
				latch_d     = val;
				latch_we    = 1'b1;
				want_push   = 1'b1;
				q_job.kind  = gpec_pkg::KIND_PIN;
				q_job.word  = val;
				q_job.pin   = in_data.pin_index;
				q_job.level = |(val & pin_bit);
			end
			gpec_pkg::OP_READ_PORT: begin
				latch_d    = val;
				latch_we   = 1'b1;
				want_push  = 1'b1;
				q_job.kind = gpec_pkg::KIND_PORT;
				q_job.word = val;
			end
			gpec_pkg::OP_RESET_PORT: begin
				latch_d    = mask;
				latch_we   = 1'b1;
				want_push  = 1'b1;
				q_job.kind = gpec_pkg::KIND_SENT;
				q_job.word = mask;
			end
			gpec_pkg::OP_SCAN: begin
				latch_d       = val;
				latch_we      = 1'b1;
				want_push     = (diff != '0);
				q_job.scan    = 1'b1;
				q_job.kind    = gpec_pkg::KIND_EVENT;
				q_job.word    = val;
				q_job.changed = diff;
			end
			default: begin
				latch_we = 1'b0;
			end
		endcase
	end

	assign q_push = accept && want_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q  <= '0;
			latch_q <= '0;
		end else begin
			if (cfg_valid) begin
				mask_q <= cfg_data;
			end
			if (accept && latch_we) begin
				latch_q <= latch_d;
			end
		end
	end

endmodule

[rtl/gpec_back.sv]
// Back end: queued jobs to beats, one changed pin per cycle for scans unless stalled.
`timescale 1ns / 1ps

module gpec_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_avail,
	input  gpec_pkg::job_t       q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gpec_pkg::out_item_t  out_data
);

	gpec_pkg::job_t      cur_q;
	logic                busy_q;
	logic                out_valid_q;
	gpec_pkg::out_item_t out_data_q;
	gpec_pkg::out_item_t beat;
	logic [15:0]         lowest;
	logic [15:0]         rest;
	logic [3:0]          low_pin;
	logic                can_emit;
	logic                done;

	assign lowest = cur_q.changed & (~cur_q.changed + 16'd1);
	assign rest   = cur_q.changed & ~lowest;

	always_comb begin
		low_pin = '0;
		for (int i = 0; i < 16; i++) begin
			if (lowest[i]) begin
				low_pin = low_pin | 4'(i);
			end
		end
	end

	always_comb begin
		beat.result_kind = cur_q.kind;
		beat.port_word   = cur_q.word;
		if (cur_q.scan) begin
			beat.pin_number = low_pin;
			beat.level_out  = |(cur_q.word & lowest);
			beat.last       = (rest == '0);
		end else begin
			beat.pin_number = cur_q.pin;
			beat.level_out  = cur_q.level;
			beat.last       = 1'b1;
		end
	end

	assign can_emit  = busy_q && (!out_valid_q || out_ready);
	assign done      = can_emit && beat.last;
	assign q_pop     = q_avail && (!busy_q || done);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (can_emit) begin
			out_data_q <= beat;
		end
		if (q_pop) begin
			cur_q <= q_head;
		end else if (can_emit) begin
			cur_q.changed <= rest;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/gpio_expander_port_change_detect_core.sv]
// Top level of the quasi-bidirectional port expander with pin change detection.
`timescale 1ns / 1ps

// The block models a quasi-bidirectional port expander. Each input beat is one
// operation on the port latch: write the port, set or clear one pin, reset the
// port to the input-pin mask, read the port, read one pin, or sample and scan.
// Every word sent to the port has the input-pin mask ORed in, so input pins
// are always held weakly high. A scan compares the previous latch with the new
// sample on input pins only and gives one event beat per changed pin, lowest
// pin first, with the last flag on the highest; when no input pin changed the
// scan gives no beat at all, and unused operation codes are dropped silently.
// The front end takes one operation every cycle while its job queue (two
// entries) has room, and updates the latch at once, so consecutive operations
// see each other's effects without delay. The back end drains the queue: an
// operation with a single result gives one beat, a scan one beat per changed
// input pin, so from 1 to 16 beats; the one-pin-per-cycle scan loop, while the
// output is not stalled, sets the sustained rate under long scans. A result
// passes from the queue through the current-job register into the output
// register and waits there, with the next beat already prepared, until taken.
// The mask register is written through the configuration channel, which is
// always ready; it should be written only while the block holds no work.
// Both registers reset to zero; the latch width follows PORT_WIDTH, and bits
// at or above the port width always read as zero.

module gpio_expander_port_change_detect_core #(
	parameter int PORT_WIDTH = gpec_pkg::PORT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  gpec_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output gpec_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [15:0]          cfg_data
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_avail;
	gpec_pkg::job_t q_job;
	gpec_pkg::job_t q_head;

	// The mask register can always be written in the cycle it is offered.
	assign cfg_ready = 1'b1;

	gpec_front #(
		.PORT_WIDTH (PORT_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	// Jobs wait here so that a long scan on the output side stalls the acceptance
	// of the next operations only once the queue is full.
	gpec_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (q_head)
	);

	gpec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_avail   (q_avail),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[rtl/gpec_checker.sv]
// Port-level checker for the port change detector, bound to the top level.
`timescale 1ns / 1ps
`include "gpio_expander_port_change_detect_core_defines.svh"

module gpec_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  gpec_pkg::out_item_t  out_data,
	input  logic                 cfg_ready
);

	// A stalled result beat must hold its payload.
	`GPEC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

	// Pin reads and change events report the level of that pin in the word.
	`GPEC_ASSERT_NOW(a_level_match, clk, arst_n, out_valid && (out_data.result_kind == gpec_pkg::KIND_PIN || out_data.result_kind == gpec_pkg::KIND_EVENT), out_data.level_out == out_data.port_word[out_data.pin_number], "reported level does not match the port word")

	// Every operation other than a scan gives exactly one beat, so each such beat carries the last flag.
	`GPEC_ASSERT_NOW(a_single_last, clk, arst_n, out_valid && out_data.result_kind != gpec_pkg::KIND_EVENT, out_data.last, "single-result beat without last")

	// The mask register never refuses a write.
	`GPEC_ASSERT_NOW(a_cfg_ready, clk, arst_n, 1'b1, cfg_ready, "configuration channel not ready")

endmodule

bind gpio_expander_port_change_detect_core gpec_checker u_gpec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);
